[hw/rtl/vcrp_pkg.sv]
// Shared constants, types and codes for the video controller register port.
package vcrp_pkg;

    localparam int REG_COUNT_DEF = 37;
    localparam int VMEM_DEPTH_DEF = 65536;

    localparam logic [5:0] IDX_ADDR_HI = 6'h12;
    localparam logic [5:0] IDX_ADDR_LO = 6'h13;
    localparam logic [5:0] IDX_MODE = 6'h18;
    localparam logic [5:0] IDX_COUNT = 6'h1e;
    localparam logic [5:0] IDX_DATA = 6'h1f;
    localparam logic [5:0] IDX_SRC_HI = 6'h20;
    localparam logic [5:0] IDX_SRC_LO = 6'h21;

    localparam logic [7:0] STATUS_MASK = 8'h80;
    localparam logic [7:0] UNKNOWN_DATA = 8'hff;
    localparam logic [15:0] MASK_16K = 16'h3fff;
    localparam logic [15:0] MASK_64K = 16'hffff;

    // Operation decoded by the front end
    typedef enum logic [2:0] {
        OP_READ_IDX,
        OP_WRITE_IDX,
        OP_READ_REG,
        OP_WRITE_REG,
        OP_READ_CONST
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] idx;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEM_READ,
        ST_MEM_WAIT,
        ST_BLOCK_READ,
        ST_BLOCK_WAIT,
        ST_BLOCK_WRITE,
        ST_REG_WAIT
    } state_t;

endpackage

[hw/rtl/vcrp_front.sv]
// Front end: holds the register index, decodes accesses into commands and queues them.
module vcrp_front #(
    parameter int RegCount = vcrp_pkg::REG_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            command,
    input  logic            port_select,
    input  logic [7:0]      write_data,
    input  logic            push,
    output logic            full,
    output vcrp_pkg::cmd_t  cmd,
    output logic            cmd_valid,
    input  logic            cmd_take
);
    import vcrp_pkg::*;

    localparam int QDepth = 2;

    cmd_t       q_reg [QDepth];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] index_reg, index_next;
    logic       accept;
    cmd_t       dec;

    assign full = (cnt_reg == 2'(QDepth));
    assign accept = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        dec.idx = index_reg[5:0];
        dec.data = write_data;
        if (!port_select)
        begin
            dec.op = command ? OP_WRITE_IDX : OP_READ_IDX;
            dec.data = command ? write_data : (index_reg | STATUS_MASK);
        end
        else if (32'(index_reg[5:0]) >= RegCount)
        begin
            dec.op = command ? OP_WRITE_IDX : OP_READ_CONST;
            dec.data = command ? 8'd0 : UNKNOWN_DATA;
        end
        else
        begin
            dec.op = command ? OP_WRITE_REG : OP_READ_REG;
        end
        // Unknown-index writes only need a zero result; reuse the const path
        if (port_select && command && 32'(index_reg[5:0]) >= RegCount)
        begin
            dec.op = OP_READ_CONST;
            dec.data = 8'd0;
        end
    end

    always_comb
    begin
        index_next = index_reg;
        if (accept && command && !port_select)
        begin
            index_next = write_data;
        end
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_take ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + 2'(accept) - 2'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            index_reg <= index_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDepth)) else $error("queue count overflow");
    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid) else $error("take from empty queue");
    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !full && command && !port_select) |=> $stable(index_reg))
        else $error("index changed without index write");
`endif

endmodule

[hw/rtl/vcrp_back.sv]
// Back end: register file, address registers, video memory and block fill/copy sequencer.
module vcrp_back #(
    parameter int RegCount = vcrp_pkg::REG_COUNT_DEF,
    parameter int VmemDepth = vcrp_pkg::VMEM_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ram_16k_only,
    input  vcrp_pkg::cmd_t  cmd,
    input  logic            cmd_valid,
    output logic            cmd_take,
    output logic [7:0]      read_data,
    output logic            empty,
    input  logic            pop
);
    import vcrp_pkg::*;

    localparam int AW = $clog2(VmemDepth);

    logic [7:0]  mem [VmemDepth];
    logic [7:0]  rf_mem [RegCount];
    logic [RegCount-1:0] rf_valid_reg;
    logic        rf_we;
    logic        rf_re;
    logic [7:0]  rf_wdata;
    logic [5:0]  rf_widx;
    logic [7:0]  rf_rdata_reg;
    logic        mode_copy_reg;
    logic [7:0]  fill_reg;

    state_t      state_reg, state_next;
    logic [15:0] upd_reg, upd_next;
    logic [15:0] src_reg, src_next;
    logic [8:0]  left_reg, left_next;
    logic [7:0]  res_reg, res_next;
    logic        full_reg, full_next;
    logic [7:0]  rdata_reg;
    logic        mem_we, mem_re;
    logic [15:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata;
    logic [15:0] amask;
    logic        out_free;

    assign amask = (ram_16k_only ? MASK_16K : MASK_64K) & 16'(VmemDepth - 1);
    assign empty = !full_reg;
    assign read_data = res_reg;
    assign out_free = !full_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        upd_next = upd_reg;
        src_next = src_reg;
        left_next = left_reg;
        res_next = res_reg;
        full_next = full_reg && !pop;
        cmd_take = 1'b0;
        rf_we = 1'b0;
        rf_re = 1'b0;
        rf_widx = cmd.idx;
        rf_wdata = cmd.data;
        mem_we = 1'b0;
        mem_waddr = upd_reg & amask;
        mem_wdata = cmd.data;
        mem_re = 1'b0;
        mem_raddr = upd_reg & amask;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    unique case (cmd.op)
                        OP_READ_IDX, OP_READ_CONST:
                        begin
                            cmd_take = 1'b1;
                            res_next = cmd.data;
                            full_next = 1'b1;
                        end
                        OP_WRITE_IDX:
                        begin
                            cmd_take = 1'b1;
                            res_next = '0;
                            full_next = 1'b1;
                        end
                        OP_READ_REG:
                        begin
                            priority case (cmd.idx)
                                IDX_ADDR_HI: res_next = upd_reg[15:8];
                                IDX_ADDR_LO: res_next = upd_reg[7:0];
                                IDX_SRC_HI:  res_next = src_reg[15:8];
                                IDX_SRC_LO:  res_next = src_reg[7:0];
                                IDX_COUNT:   res_next = '0;
                                IDX_DATA:
                                begin
                                    mem_re = 1'b1;
                                    state_next = ST_MEM_WAIT;
                                end
                                default:
                                begin
                                    rf_re = 1'b1;
                                    state_next = ST_REG_WAIT;
                                end
                            endcase
                            if (state_next == ST_IDLE)
                            begin
                                cmd_take = 1'b1;
                                full_next = 1'b1;
                            end
                        end
                        OP_WRITE_REG:
                        begin
                            res_next = '0;
                            priority case (cmd.idx)
                                IDX_ADDR_HI: upd_next = {cmd.data, upd_reg[7:0]};
                                IDX_ADDR_LO: upd_next = {upd_reg[15:8], cmd.data};
                                IDX_SRC_HI:  src_next = {cmd.data, src_reg[7:0]};
                                IDX_SRC_LO:  src_next = {src_reg[15:8], cmd.data};
                                IDX_DATA:
                                begin
                                    rf_we = 1'b1;
                                    mem_we = 1'b1;
                                    upd_next = upd_reg + 16'd1;
                                end
                                default:     rf_we = 1'b1;
                            endcase
                            if (cmd.idx == IDX_COUNT)
                            begin
                                left_next = (cmd.data == 8'd0) ? 9'd256 : {1'b0, cmd.data};
                                state_next = mode_copy_reg ? ST_BLOCK_READ : ST_BLOCK_WRITE;
                            end
                            else
                            begin
                                cmd_take = 1'b1;
                                full_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            ST_MEM_WAIT:
            begin
                res_next = rdata_reg;
                full_next = 1'b1;
                cmd_take = 1'b1;
                state_next = ST_IDLE;
            end
            ST_REG_WAIT:
            begin
                // never-written entries read as zero
                res_next = rf_valid_reg[cmd.idx] ? rf_rdata_reg : 8'd0;
                full_next = 1'b1;
                cmd_take = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BLOCK_READ:
            begin
                mem_re = 1'b1;
                mem_raddr = src_reg & amask;
                src_next = src_reg + 16'd1;
                state_next = ST_BLOCK_WAIT;
            end
            ST_BLOCK_WAIT:
            begin
                mem_we = 1'b1;
                mem_wdata = rdata_reg;
                upd_next = upd_reg + 16'd1;
                left_next = left_reg - 9'd1;
                state_next = (left_reg == 9'd1) ? ST_IDLE : ST_BLOCK_READ;
                if (left_reg == 9'd1)
                begin
                    cmd_take = 1'b1;
                    full_next = 1'b1;
                end
            end
            ST_BLOCK_WRITE:
            begin
                mem_we = 1'b1;
                mem_wdata = fill_reg;
                upd_next = upd_reg + 16'd1;
                left_next = left_reg - 9'd1;
                if (left_reg == 9'd1)
                begin
                    state_next = ST_IDLE;
                    cmd_take = 1'b1;
                    full_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            upd_reg <= '0;
            src_reg <= '0;
            left_reg <= '0;
            full_reg <= 1'b0;
            rf_valid_reg <= '0;
            mode_copy_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            upd_reg <= upd_next;
            src_reg <= src_next;
            left_reg <= left_next;
            full_reg <= full_next;
            if (rf_we)
            begin
                rf_valid_reg[rf_widx] <= 1'b1;
                if (rf_widx == IDX_MODE)
                begin
                    mode_copy_reg <= rf_wdata[7];
                end
                if (rf_widx == IDX_DATA)
                begin
                    fill_reg <= rf_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_widx] <= rf_wdata;
        end
        if (rf_re)
        begin
            rf_rdata_reg <= rf_mem[cmd.idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr[AW-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid) else $error("command taken while none queued");
    a_take_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> full_reg) else $error("command retired without result");
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLOCK_WRITE || state_reg == ST_BLOCK_WAIT) |-> left_reg != 9'd0)
        else $error("block count underflow");
`endif

endmodule

[hw/rtl/video_controller_register_port.sv]
// Top level of the video controller register port: front decoder, command queue, back end.
// Index, address and count reads and non-count writes complete in the idle state; register
// file and data reads pass a wait state; a fill writes, a copy reads then writes, each byte.
// Throughput: one idle-state access per cycle while results are popped; a held result
// stalls the back end, and two commands queue ahead of it before full rises.
// Reset clears index, addresses, queues and register valid bits (not video memory).
module video_controller_register_port #(
    parameter int RegCount = vcrp_pkg::REG_COUNT_DEF,
    parameter int VmemDepth = vcrp_pkg::VMEM_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       command,
    input  logic       port_select,
    input  logic [7:0] write_data,
    input  logic       push,
    output logic       full,
    output logic [7:0] read_data,
    output logic       empty,
    input  logic       pop
);
    import vcrp_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;
    logic ram16_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram16_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            ram16_reg <= cfg_data;
        end
    end

    vcrp_front #(.RegCount(RegCount)) u_front (
        .clk(clk), .rst_n(rst_n), .command(command), .port_select(port_select),
        .write_data(write_data), .push(push), .full(full), .cmd(cmd),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    vcrp_back #(.RegCount(RegCount), .VmemDepth(VmemDepth)) u_back (
        .clk(clk), .rst_n(rst_n), .ram_16k_only(ram16_reg), .cmd(cmd),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .read_data(read_data),
        .empty(empty), .pop(pop)
    );

endmodule
